@@ rtl/core/ptb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants for the palindromic tree builder.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int CNT_W        = 11;

  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_COMPUTE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  letter;
    logic [10:0] node_index;
  } ptb_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               new_node;
    logic [10:0]        node;
    logic signed [11:0] pal_length;
    logic [10:0]        suffix_count;
    logic [10:0]        occurrences;
  } ptb_out_t;

endpackage

@@ rtl/core/ptb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/palindromic_tree_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_tree_builder
// Eertree builder: append letters, compute occurrence counts, read nodes.
// An append walks suffix links; a new node may need a second walk to find its
// link. Compute passes over every node, then back over the non-root nodes; a full
// store, a read, a bad node or an unused mode give a result without any walk.
// One request at a time; busy stays high until the result strobe.
// After reset a clearing pass over all NODE_CAP*ALPHABET edge entries
// (26676 by default) runs with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module palindromic_tree_builder #(
  parameter int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ptb_pkg::ptb_in_t  in_req,
  output logic              out_valid,
  output ptb_pkg::ptb_out_t out_rsp
);
  import ptb_pkg::*;

  localparam int NODE_CAP = MAX_LEN + 2;
  localparam int NW       = $clog2(NODE_CAP + 1);
  localparam int NAW      = $clog2(NODE_CAP);
  localparam int TW       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LCW      = $clog2(MAX_LEN + 1);
  localparam int LW       = $clog2(ALPHABET);
  localparam int EDEPTH   = NODE_CAP * ALPHABET;
  localparam int EW       = $clog2(EDEPTH);
  localparam int SW       = NW + 1;
  localparam int BW       = NW + 3;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_W0   = 5'd2;
  localparam logic [4:0] S_W1   = 5'd3;
  localparam logic [4:0] S_W2   = 5'd4;
  localparam logic [4:0] S_FND  = 5'd5;
  localparam logic [4:0] S_E1   = 5'd6;
  localparam logic [4:0] S_E2   = 5'd7;
  localparam logic [4:0] S_SC0  = 5'd8;
  localparam logic [4:0] S_SC1  = 5'd9;
  localparam logic [4:0] S_R0   = 5'd10;
  localparam logic [4:0] S_R1   = 5'd11;
  localparam logic [4:0] S_CP0  = 5'd12;
  localparam logic [4:0] S_CP1  = 5'd13;
  localparam logic [4:0] S_P0   = 5'd14;
  localparam logic [4:0] S_P1   = 5'd15;
  localparam logic [4:0] S_P2   = 5'd16;

  localparam logic [1:0] K_APPEND = 2'd0;
  localparam logic [1:0] K_FULL   = 2'd1;
  localparam logic [1:0] K_READ   = 2'd2;

  logic [4:0]           state_r, state_nxt;
  logic [EW-1:0]        clr_r, clr_nxt;
  logic [LCW-1:0]       tlen_r, tlen_nxt;
  logic [TW-1:0]        pos_r, pos_nxt;
  logic [NW-1:0]        total_r, total_nxt;
  logic [NW-1:0]        cur_r, cur_nxt;
  logic [LW-1:0]        let_r, let_nxt;
  logic [NW-1:0]        x_r, x_nxt;
  logic                 phase_r, phase_nxt;
  logic signed [SW-1:0] len_r, len_nxt;
  logic [NW-1:0]        link_r, link_nxt;
  logic [NW-1:0]        s_r, s_nxt;
  logic signed [SW-1:0] slen_r, slen_nxt;
  logic [NW-1:0]        slink_r, slink_nxt;
  logic [EW-1:0]        eaddr_r, eaddr_nxt;
  logic [NW-1:0]        nn_r, nn_nxt;
  logic [NW-1:0]        lk_r, lk_nxt;
  logic                 new_r, new_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [NW-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]     v_r, v_nxt;
  ptb_out_t             out_r, out_nxt;
  logic                 valid_r, valid_nxt;

  logic                 text_we;
  logic [TW-1:0]        text_waddr, text_raddr;
  logic [LW-1:0]        text_wdata, text_rd;
  logic                 edge_we;
  logic [EW-1:0]        edge_waddr, edge_raddr;
  logic [NW-1:0]        edge_wdata, edge_rd;
  logic [NAW-1:0]       node_waddr, node_raddr;
  logic                 len_we, link_we, sc_we, max_we;
  logic signed [SW-1:0] len_wdata, len_rd;
  logic [NW-1:0]        link_wdata, link_rd;
  logic [CNT_W-1:0]     sc_wdata, sc_rd, max_wdata, max_rd;
  logic                 occ_we;
  logic [NAW-1:0]       occ_waddr, occ_raddr;
  logic [CNT_W-1:0]     occ_wdata, occ_rd;

  logic [LW-1:0]        let_sat;
  logic signed [BW-1:0] bef;

  ptb_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_text (
    .clk, .we(text_we), .waddr(text_waddr), .wdata(text_wdata),
    .raddr(text_raddr), .rdata(text_rd));
  ptb_ram #(.WIDTH(NW), .DEPTH(EDEPTH)) u_edge (
    .clk, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rd));
  ptb_ram #(.WIDTH(SW), .DEPTH(NODE_CAP)) u_len (
    .clk, .we(len_we), .waddr(node_waddr), .wdata(len_wdata),
    .raddr(node_raddr), .rdata(len_rd));
  ptb_ram #(.WIDTH(NW), .DEPTH(NODE_CAP)) u_link (
    .clk, .we(link_we), .waddr(node_waddr), .wdata(link_wdata),
    .raddr(node_raddr), .rdata(link_rd));
  ptb_ram #(.WIDTH(CNT_W), .DEPTH(NODE_CAP)) u_sc (
    .clk, .we(sc_we), .waddr(node_waddr), .wdata(sc_wdata),
    .raddr(node_raddr), .rdata(sc_rd));
  ptb_ram #(.WIDTH(CNT_W), .DEPTH(NODE_CAP)) u_max (
    .clk, .we(max_we), .waddr(node_waddr), .wdata(max_wdata),
    .raddr(node_raddr), .rdata(max_rd));
  ptb_ram #(.WIDTH(CNT_W), .DEPTH(NODE_CAP)) u_occ (
    .clk, .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr(occ_raddr), .rdata(occ_rd));

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_rsp   = out_r;

  assign let_sat = (32'(in_req.letter) >= ALPHABET) ? LW'(ALPHABET - 1) : LW'(in_req.letter);
  assign bef     = BW'($signed({1'b0, pos_r})) - BW'(len_rd) - BW'(1);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    tlen_nxt  = tlen_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    cur_nxt   = cur_r;
    let_nxt   = let_r;
    x_nxt     = x_r;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    link_nxt  = link_r;
    s_nxt     = s_r;
    slen_nxt  = slen_r;
    slink_nxt = slink_r;
    eaddr_nxt = eaddr_r;
    nn_nxt    = nn_r;
    lk_nxt    = lk_r;
    new_nxt   = new_r;
    kind_nxt  = kind_r;
    i_nxt     = i_r;
    v_nxt     = v_r;
    out_nxt   = out_r;
    valid_nxt = 1'b0;

    text_we    = 1'b0;
    text_waddr = pos_r;
    text_wdata = let_r;
    text_raddr = TW'(bef);
    edge_we    = 1'b0;
    edge_waddr = eaddr_r;
    edge_wdata = total_r;
    edge_raddr = eaddr_r;
    node_waddr = NAW'(nn_r);
    node_raddr = NAW'(x_r);
    len_we     = 1'b0;
    link_we    = 1'b0;
    sc_we      = 1'b0;
    max_we     = 1'b0;
    len_wdata  = slen_r + SW'(2);
    link_wdata = lk_r;
    sc_wdata   = sc_rd + CNT_W'(1);
    max_wdata  = max_rd + CNT_W'(1);
    occ_we     = 1'b0;
    occ_waddr  = NAW'(i_r);
    occ_wdata  = max_rd;
    occ_raddr  = NAW'(x_r);

    unique case (state_r)
      S_CLR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_r;
        edge_wdata = '0;
        if (32'(clr_r) < NODE_CAP) begin
          node_waddr = NAW'(clr_r);
          occ_waddr  = NAW'(clr_r);
          len_we     = 1'b1;
          link_we    = 1'b1;
          sc_we      = 1'b1;
          max_we     = 1'b1;
          occ_we     = 1'b1;
          len_wdata  = (clr_r == '0) ? -SW'(1) : '0;
          link_wdata = '0;
          sc_wdata   = '0;
          max_wdata  = '0;
          occ_wdata  = '0;
        end
        if (32'(clr_r) == EDEPTH - 1) begin
          state_nxt = S_IDLE;
        end
        clr_nxt = clr_r + EW'(1);
      end
      S_IDLE: begin
        if (start) begin
          out_nxt = '0;
          new_nxt = 1'b0;
          unique case (in_req.mode)
            MODE_APPEND: begin
              x_nxt = cur_r;
              if (tlen_r == LCW'(MAX_LEN)) begin
                kind_nxt  = K_FULL;
                state_nxt = S_R0;
              end else begin
                text_we    = 1'b1;
                text_waddr = TW'(tlen_r);
                text_wdata = let_sat;
                pos_nxt    = TW'(tlen_r);
                tlen_nxt   = tlen_r + LCW'(1);
                let_nxt    = let_sat;
                phase_nxt  = 1'b0;
                kind_nxt   = K_APPEND;
                state_nxt  = S_W0;
              end
            end
            MODE_COMPUTE: begin
              i_nxt     = '0;
              state_nxt = S_CP0;
            end
            MODE_READ: begin
              if (32'(in_req.node_index) >= 32'(total_r)) begin
                out_nxt.status = ST_BAD;
                valid_nxt      = 1'b1;
              end else begin
                x_nxt     = NW'(in_req.node_index);
                kind_nxt  = K_READ;
                state_nxt = S_R0;
              end
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_W0: begin
        state_nxt = S_W1;
      end
      S_W1: begin
        len_nxt  = len_rd;
        link_nxt = link_rd;
        if (bef < 0) begin
          if (x_r == '0) begin
            state_nxt = S_FND;
          end else begin
            x_nxt     = link_rd;
            state_nxt = S_W0;
          end
        end else begin
          state_nxt = S_W2;
        end
      end
      S_W2: begin
        if (text_rd == let_r || x_r == '0) begin
          state_nxt = S_FND;
        end else begin
          x_nxt     = link_r;
          state_nxt = S_W0;
        end
      end
      S_FND: begin
        s_nxt = x_r;
        if (!phase_r) begin
          slen_nxt  = len_r;
          slink_nxt = link_r;
        end
        eaddr_nxt = EW'(x_r) * EW'(ALPHABET) + EW'(let_r);
        state_nxt = S_E1;
      end
      S_E1: begin
        state_nxt = S_E2;
      end
      S_E2: begin
        if (phase_r) begin
          lk_nxt    = edge_rd;
          state_nxt = S_SC0;
        end else if (edge_rd == '0 && 32'(total_r) < NODE_CAP) begin
          edge_we   = 1'b1;
          nn_nxt    = total_r;
          total_nxt = total_r + NW'(1);
          new_nxt   = 1'b1;
          if (s_r == '0) begin
            lk_nxt    = NW'(1);
            state_nxt = S_SC0;
          end else begin
            x_nxt     = slink_r;
            phase_nxt = 1'b1;
            state_nxt = S_W0;
          end
        end else begin
          x_nxt     = (32'(edge_rd) >= NODE_CAP) ? NW'(1) : edge_rd;
          state_nxt = S_R0;
        end
      end
      S_SC0: begin
        node_raddr = NAW'(lk_r);
        state_nxt  = S_SC1;
      end
      S_SC1: begin
        len_we    = 1'b1;
        link_we   = 1'b1;
        sc_we     = 1'b1;
        max_we    = 1'b1;
        max_wdata = '0;
        x_nxt     = nn_r;
        state_nxt = S_R0;
      end
      S_R0: begin
        state_nxt = S_R1;
      end
      S_R1: begin
        out_nxt.node         = 11'(x_r);
        out_nxt.pal_length   = 12'(len_rd);
        out_nxt.suffix_count = sc_rd;
        if (kind_r == K_FULL) begin
          out_nxt.status = ST_FULL;
        end
        if (kind_r == K_READ) begin
          out_nxt.occurrences = occ_rd;
        end
        if (kind_r == K_APPEND) begin
          out_nxt.new_node = new_r;
          node_waddr       = NAW'(x_r);
          max_we           = 1'b1;
          cur_nxt          = x_r;
        end
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CP0: begin
        node_raddr = NAW'(i_r);
        state_nxt  = S_CP1;
      end
      S_CP1: begin
        occ_we = 1'b1;
        if (i_r + NW'(1) == total_r) begin
          if (total_r > NW'(2)) begin
            i_nxt     = i_r;
            state_nxt = S_P0;
          end else begin
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          i_nxt     = i_r + NW'(1);
          state_nxt = S_CP0;
        end
      end
      S_P0: begin
        node_raddr = NAW'(i_r);
        occ_raddr  = NAW'(i_r);
        state_nxt  = S_P1;
      end
      S_P1: begin
        lk_nxt    = link_rd;
        v_nxt     = occ_rd;
        occ_raddr = NAW'(link_rd);
        state_nxt = S_P2;
      end
      S_P2: begin
        occ_we    = 1'b1;
        occ_waddr = NAW'(lk_r);
        occ_wdata = occ_rd + v_r;
        if (i_r == NW'(2)) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r - NW'(1);
          state_nxt = S_P0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      tlen_r  <= '0;
      total_r <= NW'(2);
      cur_r   <= NW'(1);
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      tlen_r  <= tlen_nxt;
      total_r <= total_nxt;
      cur_r   <= cur_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    let_r   <= let_nxt;
    x_r     <= x_nxt;
    phase_r <= phase_nxt;
    len_r   <= len_nxt;
    link_r  <= link_nxt;
    s_r     <= s_nxt;
    slen_r  <= slen_nxt;
    slink_r <= slink_nxt;
    eaddr_r <= eaddr_nxt;
    nn_r    <= nn_nxt;
    lk_r    <= lk_nxt;
    new_r   <= new_nxt;
    kind_r  <= kind_nxt;
    i_r     <= i_nxt;
    v_r     <= v_nxt;
    out_r   <= out_nxt;
  end
endmodule
